@@ rtl/bd3_pkg.sv @@
`default_nettype none

package bd3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int CIDX_W = 2;
    localparam int SIZE_W = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 4)
                          ? $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 4);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = SIZE_W;
    localparam int OC_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int N_W    = OC_W + 1;
    localparam int DIVC_W = $clog2(OC_W);

    localparam int OUT_DEPTH = 3;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FOREGROUND   = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd256;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd256;
    localparam logic [PIX_W-1:0] RST_FOREGROUND   = 8'd255;

    typedef struct packed {
        logic             frame_last;
        logic [PIX_W-1:0] pixel_out;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/binary_dilate_3x3_top.sv @@
`default_nettype none

// 3x3 eight-neighbour binary dilation over a raster pixel stream.
// latency: a result word passes the stage b registers and the output queue before it
//   shows on m_axis; in stream terms output trails input by one line plus one pixel.
// throughput: one word per cycle while the output queue has room, set by the
//   read-modify-write of the dual-port line ram; after each configuration write
//   the input stalls while a serial divider re-derives the output row and column.
// reset: synchronous, active low; counters, window and output queue clear, the
//   line ram is not cleared (entries outside the frame are masked).
module binary_dilate_3x3_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  wire  [0:0]  s_axis_tuser,   // [0] mode: 0 pixel, 1 drain tick
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic        m_axis_tlast,   // frame_last
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_data
);

    localparam int PIX_W  = bd3_pkg::PIX_W;
    localparam int SIZE_W = bd3_pkg::SIZE_W;
    localparam int COL_W  = bd3_pkg::COL_W;
    localparam int ROW_W  = bd3_pkg::ROW_W;
    localparam int OC_W   = bd3_pkg::OC_W;
    localparam int N_W    = bd3_pkg::N_W;
    localparam int DIVC_W = bd3_pkg::DIVC_W;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } t_state;

    // which neighbour rows and columns lie inside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge_ok;

    // ------------------------------------------------------------------
    // configuration, stored already clamped to the legal range
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] r_wc;
    logic [SIZE_W-1:0] r_hc;
    logic [PIX_W-1:0]  r_fg;
    logic [N_W-1:0]    r_n;
    logic              cfg_acc;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [bd3_pkg::CFG_W-1:0] v,
        input int                        hi
    );
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (32'(v) > hi) begin
            return SIZE_W'(hi);
        end
        return SIZE_W'(v);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= clamp_size(bd3_pkg::RST_FRAME_WIDTH, bd3_pkg::MAX_WIDTH);
            r_hc <= clamp_size(bd3_pkg::RST_FRAME_HEIGHT, bd3_pkg::MAX_HEIGHT);
            r_fg <= bd3_pkg::RST_FOREGROUND;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                bd3_pkg::CFG_FRAME_WIDTH:
                    r_wc <= clamp_size(i_cfg_data, bd3_pkg::MAX_WIDTH);
                bd3_pkg::CFG_FRAME_HEIGHT:
                    r_hc <= clamp_size(i_cfg_data, bd3_pkg::MAX_HEIGHT);
                bd3_pkg::CFG_FOREGROUND:
                    r_fg <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // pixels per frame; one registered multiply, settled long before the
    // divider pass after a write ends
    always_ff @(posedge i_clk) begin
        r_n <= N_W'(r_wc * r_hc);
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    t_state            r_state;
    logic [COL_W-1:0]  r_col;     // input column
    logic [ROW_W-1:0]  r_row;     // input row, counts pushes past frame end
    logic [OC_W-1:0]   r_oc;      // words emitted in this frame
    logic [ROW_W-1:0]  r_orow;    // r_oc / width
    logic [COL_W-1:0]  r_ocol;    // r_oc % width

    // serial divider state
    logic [OC_W-1:0]   r_div_q;
    logic [COL_W-1:0]  r_div_rem;
    logic [DIVC_W-1:0] r_div_cnt;
    logic [COL_W:0]    div_rem_sh;
    logic              div_ge;
    logic [COL_W:0]    div_rem_nx;
    logic [OC_W-1:0]   div_q_nx;

    // stage b: line ram data returns, window shifts, result forms
    logic              r_b_valid;
    logic [COL_W-1:0]  r_b_col;
    logic [PIX_W-1:0]  r_b_v;
    logic              r_b_fwd;
    logic              r_b_emit;
    logic              r_b_last;
    t_edge_ok          r_b_edge;
    logic [PIX_W-1:0]  r_wr_up;   // last word written to the ram, for forwarding
    logic [PIX_W-1:0]  r_wr_mid;

    logic [PIX_W-1:0]  r_win [3][3];   // [line 0 upper..2 lower][column 0 newest]

    // fifo
    bd3_pkg::t_result             fifo_in;
    bd3_pkg::t_result             fifo_out;
    logic                         fifo_valid;
    logic [bd3_pkg::OCNT_W-1:0]   fifo_count;
    logic                         in_acc;
    logic                         out_acc;

    // ------------------------------------------------------------------
    // stage a: counters and decisions for the word being accepted
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;
    logic [OC_W-1:0]   a_oc;
    logic [ROW_W-1:0]  a_orow;
    logic [COL_W-1:0]  a_ocol;
    logic [ROW_W-1:0]  h_row;
    logic [ROW_W-1:0]  h_p1;
    logic [ROW_W-1:0]  h_p2;
    logic              a_in_frame;
    logic              a_push;
    logic              a_emit;
    logic              a_last;
    logic [PIX_W-1:0]  a_v;
    t_edge_ok          a_edge;
    logic              a_fwd;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] ocol_inc;
    logic [N_W-1:0]    oc_inc;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [OC_W-1:0]   n_oc;
    logic [ROW_W-1:0]  n_orow;
    logic [COL_W-1:0]  n_ocol;

    assign h_row = ROW_W'(r_hc);
    assign h_p1  = h_row + ROW_W'(1);
    assign h_p2  = h_row + ROW_W'(2);

    always_comb begin
        a_col  = r_col;
        a_row  = r_row;
        a_oc   = r_oc;
        a_orow = r_orow;
        a_ocol = r_ocol;
        // counters that no longer fit the frame start a new one
        if ((SIZE_W'(r_col) >= r_wc) || (r_row > h_p2) || (N_W'(r_oc) >= r_n)) begin
            a_col  = '0;
            a_row  = '0;
            a_oc   = '0;
            a_orow = '0;
            a_ocol = '0;
        end
        // more pushes than a frame plus its drain needs
        if (((a_row == h_p1) && (a_col > COL_W'(1)))
            || ((a_row == h_p2) && (r_wc >= SIZE_W'(2)))) begin
            a_col  = '0;
            a_row  = '0;
            a_oc   = '0;
            a_orow = '0;
            a_ocol = '0;
        end

        a_in_frame = (a_row < h_row);
        // a drain tick while pixels are still due is dropped
        a_push     = !(a_in_frame && s_axis_tuser[0]);
        a_v        = a_in_frame ? s_axis_tdata : '0;
        // first output once the window holds line one, column one
        a_emit     = a_push && !((a_row == '0) || ((a_row == ROW_W'(1)) && (a_col == '0)));
        a_last     = (N_W'(a_oc) == (r_n - N_W'(1)));

        a_edge.top    = (a_orow != '0);
        a_edge.bottom = ((a_orow + ROW_W'(1)) < h_row);
        a_edge.left   = (a_ocol != '0);
        a_edge.right  = ((SIZE_W'(a_ocol) + SIZE_W'(1)) < r_wc);

        // the word in stage b writes this column in the same cycle
        a_fwd = r_b_valid && (r_b_col == a_col);

        n_col  = a_col;
        n_row  = a_row;
        n_oc   = a_oc;
        n_orow = a_orow;
        n_ocol = a_ocol;

        col_inc = SIZE_W'(a_col) + SIZE_W'(1);
        if (a_push) begin
            if (col_inc >= r_wc) begin
                n_col = '0;
                n_row = a_row + ROW_W'(1);
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end

        oc_inc   = N_W'(a_oc) + N_W'(1);
        ocol_inc = SIZE_W'(a_ocol) + SIZE_W'(1);
        if (a_emit) begin
            if (oc_inc >= r_n) begin
                // frame complete
                n_col  = '0;
                n_row  = '0;
                n_oc   = '0;
                n_orow = '0;
                n_ocol = '0;
            end else begin
                n_oc = oc_inc[OC_W-1:0];
                if (ocol_inc >= r_wc) begin
                    n_ocol = '0;
                    n_orow = a_orow + ROW_W'(1);
                end else begin
                    n_ocol = ocol_inc[COL_W-1:0];
                end
            end
        end
    end

    // room for the word in stage b and one more in the queue
    assign s_axis_tready = (r_state == ST_RUN)
        && ((bd3_pkg::OCNT_W'(fifo_count) + bd3_pkg::OCNT_W'(r_b_valid && r_b_emit))
            <= bd3_pkg::OCNT_W'(bd3_pkg::OUT_DEPTH - 1));
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // restoring divide of the output count by the new width, one bit a cycle
    assign div_rem_sh = {r_div_rem, r_div_q[OC_W-1]};
    assign div_ge     = (SIZE_W'(div_rem_sh) >= r_wc);
    assign div_rem_nx = div_ge ? COL_W'(SIZE_W'(div_rem_sh) - r_wc) : div_rem_sh;
    assign div_q_nx   = {r_div_q[OC_W-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_col     <= '0;
            r_row     <= '0;
            r_oc      <= '0;
            r_orow    <= '0;
            r_ocol    <= '0;
            r_div_cnt <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= in_acc && a_push;
            if (cfg_acc) begin
                r_state   <= ST_DIV;
                r_div_cnt <= '0;
            end else begin
                unique case (r_state)
                    ST_RUN: begin
                        if (in_acc) begin
                            r_col  <= n_col;
                            r_row  <= n_row;
                            r_oc   <= n_oc;
                            r_orow <= n_orow;
                            r_ocol <= n_ocol;
                        end
                    end
                    ST_DIV: begin
                        r_div_cnt <= r_div_cnt + DIVC_W'(1);
                        if (r_div_cnt == DIVC_W'(OC_W - 1)) begin
                            r_orow  <= div_q_nx[ROW_W-1:0];
                            r_ocol  <= div_rem_nx[COL_W-1:0];
                            r_state <= ST_RUN;
                        end
                    end
                    default: r_state <= ST_RUN;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cfg_acc) begin
            r_div_q   <= r_oc;
            r_div_rem <= '0;
        end else begin
            r_div_q   <= div_q_nx;
            r_div_rem <= div_rem_nx[COL_W-1:0];
        end
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_col  <= a_col;
            r_b_v    <= a_v;
            r_b_fwd  <= a_fwd;
            r_b_emit <= a_emit;
            r_b_last <= a_last;
            r_b_edge <= a_edge;
        end
    end

    // ------------------------------------------------------------------
    // line ram: {upper, middle} per column, read in stage a, written in b
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   b_up;
    logic [PIX_W-1:0]   b_mid;

    bd3_line_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (bd3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata ({b_mid, r_b_v}),
        .i_re    (in_acc && a_push),
        .i_raddr (a_col),
        .o_rdata (ram_rdata)
    );

    // forwarding covers a one-column frame, where every push hits column zero
    assign b_up  = r_b_fwd ? r_wr_up  : ram_rdata[2*PIX_W-1:PIX_W];
    assign b_mid = r_b_fwd ? r_wr_mid : ram_rdata[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_wr_up  <= b_mid;
            r_wr_mid <= r_b_v;
        end
    end

    // ------------------------------------------------------------------
    // window shift and dilation
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] n_win [3][3];
    logic [PIX_W-1:0] centre;
    logic             hit;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            n_win[t][2] = r_win[t][1];
            n_win[t][1] = r_win[t][0];
        end
        n_win[0][0] = b_up;
        n_win[1][0] = b_mid;
        n_win[2][0] = r_b_v;

        row_ok = {r_b_edge.bottom, 1'b1, r_b_edge.top};
        // column 0 is the right neighbour, column 2 the left one
        col_ok = {r_b_edge.left, 1'b1, r_b_edge.right};

        centre = n_win[1][1];
        hit    = 1'b0;
        for (int t = 0; t < 3; t++) begin
            for (int s = 0; s < 3; s++) begin
                if (row_ok[t] && col_ok[s] && (n_win[t][s] == r_fg)) begin
                    hit = 1'b1;
                end
            end
        end

        fifo_in.pixel_out  = ((centre == '0) && hit) ? r_fg : centre;
        fifo_in.frame_last = r_b_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 3; t++) begin
                for (int s = 0; s < 3; s++) begin
                    r_win[t][s] <= '0;
                end
            end
        end else if (r_b_valid) begin
            for (int t = 0; t < 3; t++) begin
                for (int s = 0; s < 3; s++) begin
                    r_win[t][s] <= n_win[t][s];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------
    assign out_acc = m_axis_tvalid && m_axis_tready;

    bd3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_valid && r_b_emit),
        .i_data  (fifo_in),
        .i_pop   (out_acc),
        .o_valid (fifo_valid),
        .o_data  (fifo_out),
        .o_count (fifo_count)
    );

    assign m_axis_tvalid = fifo_valid;
    assign m_axis_tdata  = fifo_out.pixel_out;
    assign m_axis_tlast  = fifo_out.frame_last;

endmodule

`default_nettype wire

@@ rtl/bd3_line_ram.sv @@
`default_nettype none

module bd3_line_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [DATA_W-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bd3_out_fifo.sv @@
`default_nettype none

module bd3_out_fifo (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  bd3_pkg::t_result             i_data,
    input  wire                          i_pop,
    output logic                         o_valid,
    output bd3_pkg::t_result             o_data,
    output logic [bd3_pkg::OCNT_W-1:0]   o_count
);

    bd3_pkg::t_result                r_buf [bd3_pkg::OUT_DEPTH];
    logic [bd3_pkg::OPTR_W-1:0]      r_wptr;
    logic [bd3_pkg::OPTR_W-1:0]      r_rptr;
    logic [bd3_pkg::OCNT_W-1:0]      r_count;
    logic                            pop_ok;

    function automatic logic [bd3_pkg::OPTR_W-1:0] ptr_next(
        input logic [bd3_pkg::OPTR_W-1:0] p
    );
        if (p == bd3_pkg::OPTR_W'(bd3_pkg::OUT_DEPTH - 1)) begin
            return '0;
        end
        return p + bd3_pkg::OPTR_W'(1);
    endfunction

    assign pop_ok  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (pop_ok) begin
                r_rptr <= ptr_next(r_rptr);
            end
            unique case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + bd3_pkg::OCNT_W'(1);
                2'b01:   r_count <= r_count - bd3_pkg::OCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire
